/* rtl/core/cll_pkg.sv */
// shared constants, types and helper functions of the cursor linked list engine
`timescale 1ns / 1ps
package cll_pkg;

  localparam int SLOTS = 16;
  localparam int LW    = $clog2(SLOTS);

  typedef logic [LW-1:0] slot_t;

  localparam logic [2:0] ST_DONE       = 3'd0;
  localparam logic [2:0] ST_EMPTY      = 3'd1;
  localparam logic [2:0] ST_NO_BEFORE  = 3'd2;
  localparam logic [2:0] ST_NO_AFTER   = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;
  localparam logic [2:0] ST_BAD_LETTER = 3'd5;
  localparam logic [2:0] ST_ALREADY    = 3'd6;

  localparam logic [4:0] FN_CLEAR    = 5'd0;
  localparam logic [4:0] FN_EMPTY    = 5'd1;
  localparam logic [4:0] FN_TO_START = 5'd2;
  localparam logic [4:0] FN_TO_END   = 5'd3;
  localparam logic [4:0] FN_AT_START = 5'd4;
  localparam logic [4:0] FN_AT_END   = 5'd5;
  localparam logic [4:0] FN_NEXT     = 5'd6;
  localparam logic [4:0] FN_BACK     = 5'd7;
  localparam logic [4:0] FN_SHOW_BEF = 5'd8;
  localparam logic [4:0] FN_SHOW_AFT = 5'd9;
  localparam logic [4:0] FN_DEL_BEF  = 5'd10;
  localparam logic [4:0] FN_DEL_AFT  = 5'd11;
  localparam logic [4:0] FN_TAKE_BEF = 5'd12;
  localparam logic [4:0] FN_TAKE_AFT = 5'd13;
  localparam logic [4:0] FN_CHG_BEF  = 5'd14;
  localparam logic [4:0] FN_CHG_AFT  = 5'd15;
  localparam logic [4:0] FN_ADD_BEF  = 5'd16;
  localparam logic [4:0] FN_ADD_AFT  = 5'd17;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LO    = 8'd97;
  localparam logic [7:0] CH_HI    = 8'd122;

  localparam logic [1:0] OP_NOP  = 2'd0;
  localparam logic [1:0] OP_SETF = 2'd1;
  localparam logic [1:0] OP_WR   = 2'd2;
  localparam logic [1:0] OP_CP   = 2'd3;

  localparam logic [1:0] OPD_ZERO = 2'd0;
  localparam logic [1:0] OPD_ONE  = 2'd1;
  localparam logic [1:0] OPD_CUR  = 2'd2;
  localparam logic [1:0] OPD_RES  = 2'd3;

  localparam logic [1:0] RES_PREV = 2'd0;
  localparam logic [1:0] RES_NEXT = 2'd1;
  localparam logic [1:0] RES_FREE = 2'd2;

  localparam logic [1:0] CUR_HEAD = 2'd0;
  localparam logic [1:0] CUR_TAIL = 2'd1;
  localparam logic [1:0] CUR_RES  = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] a;
    logic [1:0] b;
  } tab_op_t;

  typedef struct packed {
    logic       load_in;
    logic       dec;
    logic [1:0] res_sel;
    logic       cur_load;
    logic [1:0] cur_sel;
    logic       elem_en;
    logic [2:0] status;
    logic       answer;
    tab_op_t    fop;
    tab_op_t    bop;
    logic       let_wr;
    logic       let_space;
    logic       init;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic cur_zero;
    logic head_zero;
    logic tail_zero;
    logic cur_is_head;
    logic cur_is_tail;
    logic prev_zero;
    logic next_zero;
    logic free_lt2;
    logic letter_ok;
  } dp_stat_t;

  function automatic slot_t init_link(input int i);
    slot_t v;
    if (i == 0) v = '0;
    else if (i + 1 < SLOTS) v = slot_t'(i + 1);
    else v = slot_t'(1);
    return v;
  endfunction

  function automatic slot_t ix(input slot_t v);
    slot_t r;
    r = (int'(v) < SLOTS) ? v : '0;
    return r;
  endfunction

  function automatic tab_op_t mk_op(input logic [1:0] kind, input logic [1:0] a,
                                    input logic [1:0] b);
    tab_op_t o;
    o.kind = kind;
    o.a    = a;
    o.b    = b;
    return o;
  endfunction

endpackage

/* rtl/core/cll_if.sv */
// request and result channel interfaces
`timescale 1ns / 1ps
interface cll_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] func;
  logic [7:0] letter;
  modport source (output valid, output func, output letter, input ready);
  modport sink (input valid, input func, input letter, output ready);
endinterface

interface cll_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       answer;
  logic [7:0] element;
  logic [3:0] cursor_slot;
  modport source (output valid, output status, output answer, output element,
                  output cursor_slot, input ready);
  modport sink (input valid, input status, input answer, input element,
                input cursor_slot, output ready);
endinterface

/* rtl/core/cursor_linked_list_engine.sv */
// top level of the cursor linked list engine
// an accepted request is decoded in S_DEC and its result loaded in S_FIN; clear, change,
//   delete, take and add pass through the update steps S_W1, S_W2, S_W3 in between, each
//   writing at most one link per table; a new request is taken only in S_IDLE, once the last
//   result is loaded, and a result still held stalls the next one in S_FIN
// reset: synchronous active-low; cleared list, cursor 0, no result pending
`timescale 1ns / 1ps
module cursor_linked_list_engine (
  input  logic      clk,
  input  logic      rst_n,
  cll_in_if.sink    in_chan,
  cll_out_if.source out_chan
);

  cll_pkg::dp_cmd_t  cmd;
  cll_pkg::dp_stat_t stat;

  cll_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_func   (in_chan.func),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cll_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_letter       (in_chan.letter),
    .stat            (stat),
    .out_status      (out_chan.status),
    .out_answer      (out_chan.answer),
    .out_element     (out_chan.element),
    .out_cursor_slot (out_chan.cursor_slot)
  );

endmodule

/* rtl/core/cll_dp.sv */
// datapath: link tables, letters, cursor and result registers
`timescale 1ns / 1ps
module cll_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  cll_pkg::dp_cmd_t cmd,
  input  logic [7:0]       in_letter,
  output cll_pkg::dp_stat_t stat,
  output logic [2:0]       out_status,
  output logic             out_answer,
  output logic [7:0]       out_element,
  output logic [3:0]       out_cursor_slot
);

  cll_pkg::slot_t fwd_r [cll_pkg::SLOTS];
  cll_pkg::slot_t bwd_r [cll_pkg::SLOTS];
  logic [7:0]     let_r [cll_pkg::SLOTS];
  cll_pkg::slot_t cursor_r;
  cll_pkg::slot_t res_r;
  logic [7:0]     letter_r;
  logic [2:0]     st_status_r;
  logic           st_answer_r;
  logic [7:0]     st_elem_r;
  logic [2:0]     out_status_r;
  logic           out_answer_r;
  logic [7:0]     out_elem_r;
  logic [3:0]     out_cursor_r;

  cll_pkg::slot_t cur, head, tail, prev, next, free, res_d;
  cll_pkg::slot_t fa, fb, ba, bb;
  cll_pkg::slot_t fidx, bidx;
  logic           fhit, bhit;
  logic [cll_pkg::LW+3:0] cext;

  function automatic cll_pkg::slot_t opd(input logic [1:0] sel, input cll_pkg::slot_t c,
                                         input cll_pkg::slot_t r);
    cll_pkg::slot_t v;
    case (sel)
      cll_pkg::OPD_ZERO: v = '0;
      cll_pkg::OPD_ONE:  v = cll_pkg::slot_t'(1);
      cll_pkg::OPD_CUR:  v = c;
      default:           v = r;
    endcase
    return v;
  endfunction

  always_comb begin
    cur  = cll_pkg::ix(cursor_r);
    head = cll_pkg::ix(fwd_r[0]);
    tail = cll_pkg::ix(bwd_r[0]);
    prev = cll_pkg::ix(bwd_r[cur]);
    next = cll_pkg::ix(fwd_r[cur]);
    free = cll_pkg::ix(fwd_r[1]);
    case (cmd.res_sel)
      cll_pkg::RES_PREV: res_d = prev;
      cll_pkg::RES_NEXT: res_d = next;
      default:           res_d = free;
    endcase
  end

  always_comb begin
    stat.cur_zero    = (cur == '0);
    stat.head_zero   = (head == '0);
    stat.tail_zero   = (tail == '0);
    stat.cur_is_head = (cur == head);
    stat.cur_is_tail = (cur == tail);
    stat.prev_zero   = (prev == '0);
    stat.next_zero   = (next == '0);
    stat.free_lt2    = (free == '0) || (free == cll_pkg::slot_t'(1));
    stat.letter_ok   = (letter_r >= cll_pkg::CH_LO) && (letter_r <= cll_pkg::CH_HI);
  end

  // first-match search for the set-first operations
  always_comb begin
    fa   = opd(cmd.fop.a, cursor_r, res_r);
    fb   = opd(cmd.fop.b, cursor_r, res_r);
    ba   = opd(cmd.bop.a, cursor_r, res_r);
    bb   = opd(cmd.bop.b, cursor_r, res_r);
    fhit = 1'b0;
    bhit = 1'b0;
    fidx = '0;
    bidx = '0;
    for (int i = cll_pkg::SLOTS - 1; i >= 0; i--) begin
      if (fwd_r[i] == fa) begin
        fhit = 1'b1;
        fidx = cll_pkg::slot_t'(i);
      end
      if (bwd_r[i] == ba) begin
        bhit = 1'b1;
        bidx = cll_pkg::slot_t'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init) begin
      for (int i = 0; i < cll_pkg::SLOTS; i++) begin
        fwd_r[i] <= cll_pkg::init_link(i);
        bwd_r[i] <= cll_pkg::init_link(i);
        let_r[i] <= cll_pkg::CH_SPACE;
      end
      cursor_r <= '0;
    end else begin
      case (cmd.fop.kind)
        cll_pkg::OP_SETF: if (fhit) fwd_r[fidx] <= fb;
        cll_pkg::OP_WR:   fwd_r[fa] <= fb;
        cll_pkg::OP_CP:   fwd_r[fa] <= fwd_r[fb];
        default: ;
      endcase
      case (cmd.bop.kind)
        cll_pkg::OP_SETF: if (bhit) bwd_r[bidx] <= bb;
        cll_pkg::OP_WR:   bwd_r[ba] <= bb;
        cll_pkg::OP_CP:   bwd_r[ba] <= bwd_r[bb];
        default: ;
      endcase
      if (cmd.let_wr) begin
        let_r[res_r] <= cmd.let_space ? cll_pkg::CH_SPACE : letter_r;
      end
      if (cmd.cur_load) begin
        case (cmd.cur_sel)
          cll_pkg::CUR_HEAD: cursor_r <= head;
          cll_pkg::CUR_TAIL: cursor_r <= tail;
          default:           cursor_r <= res_d;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      letter_r <= in_letter;
    end
    if (cmd.dec) begin
      res_r       <= res_d;
      st_status_r <= cmd.status;
      st_answer_r <= cmd.answer;
      st_elem_r   <= cmd.elem_en ? let_r[res_d] : 8'd0;
    end
    if (cmd.out_load) begin
      out_status_r <= st_status_r;
      out_answer_r <= st_answer_r;
      out_elem_r   <= st_elem_r;
      out_cursor_r <= cext[3:0];
    end
  end

  assign cext            = {4'b0000, cll_pkg::ix(cursor_r)};
  assign out_status      = out_status_r;
  assign out_answer      = out_answer_r;
  assign out_element     = out_elem_r;
  assign out_cursor_slot = out_cursor_r;

endmodule

/* rtl/core/cll_ctrl.sv */
// controller: command decode and table update sequencer
`timescale 1ns / 1ps
module cll_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [4:0]        in_func,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  cll_pkg::dp_stat_t stat,
  output cll_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_W1   = 3'd2;
  localparam logic [2:0] S_W2   = 3'd3;
  localparam logic [2:0] S_W3   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  localparam logic [2:0] PAT_NONE      = 3'd0;
  localparam logic [2:0] PAT_CLEAR     = 3'd1;
  localparam logic [2:0] PAT_CHANGE    = 3'd2;
  localparam logic [2:0] PAT_RM_BEF    = 3'd3;
  localparam logic [2:0] PAT_RM_AFT    = 3'd4;
  localparam logic [2:0] PAT_ADD_EMPTY = 3'd5;
  localparam logic [2:0] PAT_ADD_BEF   = 3'd6;
  localparam logic [2:0] PAT_ADD_AFT   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [4:0] func_r;
  logic [2:0] pat_r, pat;
  logic       out_valid_r, out_valid_nxt;
  logic       accept, slot_free, is_bef;
  logic [1:0] step;
  cll_pkg::tab_op_t op_a0, op_a1, op_a2, op_b0, op_b1, op_b2;
  cll_pkg::tab_op_t s0, s1, s2, u0, u1, u2, ad0, ad1, ad2;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;
  assign is_bef    = (func_r == cll_pkg::FN_SHOW_BEF) || (func_r == cll_pkg::FN_DEL_BEF) ||
                     (func_r == cll_pkg::FN_TAKE_BEF) || (func_r == cll_pkg::FN_CHG_BEF);

  // removal chain on the side being unlinked, copy chain on the other side
  always_comb begin
    s0  = cll_pkg::mk_op(cll_pkg::OP_SETF, cll_pkg::OPD_RES, cll_pkg::OPD_CUR);
    s1  = cll_pkg::mk_op(cll_pkg::OP_SETF, cll_pkg::OPD_ONE, cll_pkg::OPD_RES);
    s2  = cll_pkg::mk_op(cll_pkg::OP_WR, cll_pkg::OPD_RES, cll_pkg::OPD_ONE);
    u0  = cll_pkg::mk_op(cll_pkg::OP_CP, cll_pkg::OPD_CUR, cll_pkg::OPD_RES);
    u1  = cll_pkg::mk_op(cll_pkg::OP_CP, cll_pkg::OPD_ONE, cll_pkg::OPD_RES);
    u2  = cll_pkg::mk_op(cll_pkg::OP_CP, cll_pkg::OPD_RES, cll_pkg::OPD_CUR);
    ad0 = cll_pkg::mk_op(cll_pkg::OP_WR, cll_pkg::OPD_CUR, cll_pkg::OPD_RES);
    ad1 = cll_pkg::mk_op(cll_pkg::OP_SETF, cll_pkg::OPD_CUR, cll_pkg::OPD_RES);
    ad2 = cll_pkg::mk_op(cll_pkg::OP_WR, cll_pkg::OPD_RES, cll_pkg::OPD_CUR);
    op_a0 = cll_pkg::mk_op(cll_pkg::OP_NOP, cll_pkg::OPD_ZERO, cll_pkg::OPD_ZERO);
    op_a1 = op_a0;
    op_a2 = op_a0;
    op_b0 = op_a0;
    op_b1 = op_a0;
    op_b2 = op_a0;
    case (pat_r)
      PAT_RM_BEF, PAT_RM_AFT: begin
        op_a0 = s0;
        op_a1 = s1;
        op_a2 = s2;
        op_b0 = u0;
        op_b1 = s1;
        op_b2 = s2;
      end
      PAT_ADD_EMPTY: begin
        op_a0 = u1;
        op_a1 = cll_pkg::mk_op(cll_pkg::OP_WR, cll_pkg::OPD_RES, cll_pkg::OPD_ZERO);
        op_a2 = cll_pkg::mk_op(cll_pkg::OP_WR, cll_pkg::OPD_ZERO, cll_pkg::OPD_RES);
        op_b0 = op_a0;
        op_b1 = op_a1;
        op_b2 = op_a2;
      end
      PAT_ADD_BEF, PAT_ADD_AFT: begin
        op_a0 = u1;
        op_a1 = u2;
        op_a2 = ad0;
        op_b0 = u1;
        op_b1 = ad1;
        op_b2 = ad2;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (state_r)
      S_W2:    step = 2'd1;
      S_W3:    step = 2'd2;
      default: step = 2'd0;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.load_in   = accept;
    pat           = PAT_NONE;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.dec    = 1'b1;
        cmd.status = cll_pkg::ST_DONE;
        case (func_r)
          cll_pkg::FN_CLEAR: begin
            if (stat.cur_zero) cmd.status = cll_pkg::ST_EMPTY;
            else pat = PAT_CLEAR;
          end
          cll_pkg::FN_EMPTY: cmd.answer = stat.head_zero;
          cll_pkg::FN_TO_START, cll_pkg::FN_TO_END: begin
            cmd.cur_load = 1'b1;
            if (func_r == cll_pkg::FN_TO_START) begin
              cmd.cur_sel = cll_pkg::CUR_HEAD;
              if (stat.head_zero) cmd.status = cll_pkg::ST_EMPTY;
              else if (stat.cur_is_head) cmd.status = cll_pkg::ST_ALREADY;
            end else begin
              cmd.cur_sel = cll_pkg::CUR_TAIL;
              if (stat.tail_zero) cmd.status = cll_pkg::ST_EMPTY;
              else if (stat.cur_is_tail) cmd.status = cll_pkg::ST_ALREADY;
            end
          end
          cll_pkg::FN_AT_START, cll_pkg::FN_AT_END: begin
            if ((func_r == cll_pkg::FN_AT_START) ? stat.cur_is_head : stat.cur_is_tail) begin
              if (stat.cur_zero) cmd.status = cll_pkg::ST_EMPTY;
              else cmd.answer = 1'b1;
            end
          end
          cll_pkg::FN_NEXT, cll_pkg::FN_BACK, cll_pkg::FN_SHOW_BEF, cll_pkg::FN_SHOW_AFT,
          cll_pkg::FN_DEL_BEF, cll_pkg::FN_DEL_AFT, cll_pkg::FN_TAKE_BEF,
          cll_pkg::FN_TAKE_AFT, cll_pkg::FN_CHG_BEF, cll_pkg::FN_CHG_AFT: begin
            cmd.res_sel = (is_bef || func_r == cll_pkg::FN_BACK) ? cll_pkg::RES_PREV
                                                                : cll_pkg::RES_NEXT;
            if (stat.cur_zero) begin
              cmd.status = cll_pkg::ST_EMPTY;
            end else if ((is_bef || func_r == cll_pkg::FN_BACK) && stat.prev_zero) begin
              cmd.status = cll_pkg::ST_NO_BEFORE;
            end else if (!(is_bef || func_r == cll_pkg::FN_BACK) && stat.next_zero) begin
              cmd.status = cll_pkg::ST_NO_AFTER;
            end else begin
              case (func_r)
                cll_pkg::FN_NEXT, cll_pkg::FN_BACK: begin
                  cmd.cur_load = 1'b1;
                  cmd.cur_sel  = cll_pkg::CUR_RES;
                end
                cll_pkg::FN_SHOW_BEF, cll_pkg::FN_SHOW_AFT: cmd.elem_en = 1'b1;
                cll_pkg::FN_DEL_BEF: pat = PAT_RM_BEF;
                cll_pkg::FN_DEL_AFT: pat = PAT_RM_AFT;
                cll_pkg::FN_TAKE_BEF: begin
                  cmd.elem_en = 1'b1;
                  pat         = PAT_RM_BEF;
                end
                cll_pkg::FN_TAKE_AFT: begin
                  cmd.elem_en = 1'b1;
                  pat         = PAT_RM_AFT;
                end
                default: begin
                  if (!stat.letter_ok) cmd.status = cll_pkg::ST_BAD_LETTER;
                  else pat = PAT_CHANGE;
                end
              endcase
            end
          end
          cll_pkg::FN_ADD_BEF, cll_pkg::FN_ADD_AFT: begin
            cmd.res_sel = cll_pkg::RES_FREE;
            if (stat.cur_zero) begin
              if (!stat.letter_ok) cmd.status = cll_pkg::ST_BAD_LETTER;
              else if (stat.free_lt2) cmd.status = cll_pkg::ST_FULL;
              else begin
                pat          = PAT_ADD_EMPTY;
                cmd.cur_load = 1'b1;
                cmd.cur_sel  = cll_pkg::CUR_RES;
              end
            end else if (stat.free_lt2) begin
              cmd.status = cll_pkg::ST_FULL;
            end else if (!stat.letter_ok) begin
              cmd.status = cll_pkg::ST_BAD_LETTER;
            end else begin
              pat = (func_r == cll_pkg::FN_ADD_BEF) ? PAT_ADD_BEF : PAT_ADD_AFT;
            end
          end
          default: ;
        endcase
        state_nxt = (pat == PAT_NONE) ? S_FIN : S_W1;
      end
      S_W1, S_W2, S_W3: begin
        case (step)
          2'd0: begin
            cmd.fop = op_a0;
            cmd.bop = op_b0;
          end
          2'd1: begin
            cmd.fop = op_a1;
            cmd.bop = op_b1;
          end
          default: begin
            cmd.fop = op_a2;
            cmd.bop = op_b2;
          end
        endcase
        // the backward table takes the removal chain when unlinking after the cursor
        if (pat_r == PAT_RM_AFT || pat_r == PAT_ADD_BEF) begin
          cmd.fop = (step == 2'd0) ? op_b0 : (step == 2'd1) ? op_b1 : op_b2;
          cmd.bop = (step == 2'd0) ? op_a0 : (step == 2'd1) ? op_a1 : op_a2;
        end
        if (step == 2'd0) begin
          cmd.init   = (pat_r == PAT_CLEAR);
          cmd.let_wr = (pat_r == PAT_CHANGE) || (pat_r == PAT_ADD_EMPTY) ||
                       (pat_r == PAT_ADD_BEF) || (pat_r == PAT_ADD_AFT);
        end
        if (step == 2'd2) begin
          cmd.let_wr    = (pat_r == PAT_RM_BEF) || (pat_r == PAT_RM_AFT);
          cmd.let_space = 1'b1;
        end
        case (state_r)
          S_W1:    state_nxt = S_W2;
          S_W2:    state_nxt = S_W3;
          default: state_nxt = S_FIN;
        endcase
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pat_r       <= PAT_NONE;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_DEC) pat_r <= pat;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) func_r <= in_func;
  end

`ifndef SYNTH
  a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_DEC) else $error("request not decoded");
  a_dec_next: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DEC |=> state_r == S_W1 || state_r == S_FIN)
    else $error("bad state after decode");
  a_w3_fin: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_W3 |=> state_r == S_FIN) else $error("update sequence overrun");
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && slot_free |=> out_valid_r && state_r == S_IDLE)
    else $error("result not presented");
`endif

endmodule
